FILE: rtl/slsf_pkg.sv
// slsf_pkg: types, character codes and helper functions for the source line splice filter
// no dependencies; used by slsf_core, slsf_outq and source_line_splice_filter_unit
`timescale 1ns / 1ps

package slsf_pkg;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
	localparam int MAX_PUSH   = 2;

	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_BTICK  = 8'h60;

	localparam logic [2:0] DEF_LEN = 3'd7;

	typedef enum logic [1:0] {
		CM_NORMAL,
		CM_LINE,
		CM_BLOCK
	} cmode_t;

	typedef struct packed {
		cmode_t     comment_mode;
		logic       inside_string;
		logic       macro_line;
		logic       slash_seen;
		logic       backslash_held;
		logic       skip_lf_next;
		logic       star_seen;
		logic [2:0] define_match;
	} slsf_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       run_last;
		logic       frame_end;
	} slsf_res_t;

	// n results written in one cycle, r0 first
	typedef struct packed {
		logic [1:0] n;
		slsf_res_t  r0;
		slsf_res_t  r1;
	} slsf_push_t;

	typedef struct packed {
		slsf_state_t st;
		logic        emit;
	} slsf_plain_t;

	// expected byte at each position of the text define
	function automatic logic [7:0] define_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = CH_BTICK;
			3'd1: c = 8'h64;
			3'd2: c = 8'h65;
			3'd3: c = 8'h66;
			3'd4: c = 8'h69;
			3'd5: c = 8'h6e;
			3'd6: c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// ordinary text handling of one byte
	function automatic slsf_plain_t plain_byte(input slsf_state_t st_in, input logic [7:0] b,
			input logic last);
		slsf_plain_t r;
		r.st   = st_in;
		r.emit = 1'b1;
		if (b == CH_BTICK) begin
			r.st.define_match = 3'd1;
		end else if (st_in.define_match >= 3'd1 && st_in.define_match < DEF_LEN &&
				b == define_char(st_in.define_match)) begin
			if (st_in.define_match == DEF_LEN - 3'd1) begin
				r.st.macro_line   = 1'b1;
				r.st.define_match = 3'd0;
			end else begin
				r.st.define_match = st_in.define_match + 3'd1;
			end
		end else begin
			r.st.define_match = 3'd0;
		end
		if (b == CH_LF || b == CH_CR) begin
			r.st.macro_line = 1'b0;
		end else if (b == CH_SLASH) begin
			if (!last) begin
				r.st.slash_seen = 1'b1;
			end
		end else if (b == CH_QUOTE) begin
			r.st.inside_string = !st_in.inside_string;
		end else if (b == CH_BSLASH) begin
			if (!last) begin
				r.st.backslash_held = 1'b1;
				r.emit              = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/slsf_in_if.sv
// slsf_in_if: source text byte channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface slsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

FILE: rtl/slsf_out_if.sv
// slsf_out_if: flattened text result channel, valid/ready handshake
// no dependencies
`timescale 1ns / 1ps

interface slsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output frame_end, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_last,
		input frame_end, output ready);
endinterface

FILE: rtl/slsf_core.sv
// slsf_core: input register, scanner state and per-byte splice decision
// depends on slsf_pkg and slsf_in_if
`timescale 1ns / 1ps

module slsf_core (
	input  logic                clk,
	input  logic                arst_n,
	slsf_in_if.sink             raw,
	input  logic                room,
	output slsf_pkg::slsf_push_t push
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	slsf_pkg::slsf_state_t st_q;
	slsf_pkg::slsf_state_t st_d;
	slsf_pkg::slsf_state_t tmp;
	slsf_pkg::slsf_plain_t pr;
	logic                 fire;
	logic [1:0]           cnt;
	logic [7:0]           e0;
	logic [7:0]           e1;

	assign fire      = valid_s1 && room;
	assign raw.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.data_byte;
			last_s1 <= raw.frame_last;
		end
	end

	always_comb begin
		tmp  = st_q;
		pr   = slsf_pkg::plain_byte(st_q, byte_s1, last_s1);
		st_d = st_q;
		cnt  = 2'd0;
		e0   = byte_s1;
		e1   = byte_s1;
		if (st_q.comment_mode == slsf_pkg::CM_LINE) begin
			if (byte_s1 == slsf_pkg::CH_LF) begin
				tmp.comment_mode = slsf_pkg::CM_NORMAL;
				pr   = slsf_pkg::plain_byte(tmp, byte_s1, last_s1);
				st_d = pr.st;
				cnt  = {1'b0, pr.emit};
			end else begin
				cnt = 2'd1;
			end
		end else if (st_q.comment_mode == slsf_pkg::CM_BLOCK) begin
			cnt = 2'd1;
			if (st_q.star_seen && byte_s1 == slsf_pkg::CH_SLASH) begin
				st_d.comment_mode = slsf_pkg::CM_NORMAL;
				st_d.star_seen    = 1'b0;
			end else begin
				st_d.star_seen = (byte_s1 == slsf_pkg::CH_STAR);
			end
		end else if (st_q.skip_lf_next) begin
			tmp.skip_lf_next = 1'b0;
			st_d             = tmp;
			if (byte_s1 != slsf_pkg::CH_LF) begin
				pr   = slsf_pkg::plain_byte(tmp, byte_s1, last_s1);
				st_d = pr.st;
				cnt  = {1'b0, pr.emit};
			end
		end else if (st_q.backslash_held) begin
			tmp.backslash_held = 1'b0;
			st_d               = tmp;
			if ((byte_s1 == slsf_pkg::CH_LF || byte_s1 == slsf_pkg::CH_CR) &&
					(st_q.macro_line || st_q.inside_string)) begin
				// splice: the break is dropped
				if (byte_s1 == slsf_pkg::CH_CR && !last_s1) begin
					st_d.skip_lf_next = 1'b1;
				end
			end else if (st_q.inside_string && byte_s1 == slsf_pkg::CH_QUOTE) begin
				cnt = 2'd2;
				e0  = slsf_pkg::CH_BSLASH;
				e1  = slsf_pkg::CH_QUOTE;
			end else begin
				pr   = slsf_pkg::plain_byte(tmp, byte_s1, last_s1);
				st_d = pr.st;
				e0   = slsf_pkg::CH_BSLASH;
				cnt  = pr.emit ? 2'd2 : 2'd1;
			end
		end else if (st_q.slash_seen) begin
			tmp.slash_seen = 1'b0;
			st_d           = tmp;
			if (byte_s1 == slsf_pkg::CH_SLASH) begin
				cnt               = 2'd1;
				st_d.comment_mode = slsf_pkg::CM_LINE;
				st_d.define_match = 3'd0;
			end else if (byte_s1 == slsf_pkg::CH_STAR) begin
				cnt               = 2'd1;
				st_d.comment_mode = slsf_pkg::CM_BLOCK;
				st_d.star_seen    = 1'b0;
				st_d.define_match = 3'd0;
			end else begin
				pr   = slsf_pkg::plain_byte(tmp, byte_s1, last_s1);
				st_d = pr.st;
				cnt  = {1'b0, pr.emit};
			end
		end else begin
			tmp.comment_mode = slsf_pkg::CM_NORMAL;
			pr   = slsf_pkg::plain_byte(tmp, byte_s1, last_s1);
			st_d = pr.st;
			cnt  = {1'b0, pr.emit};
		end
		if (last_s1) begin
			st_d = slsf_pkg::slsf_state_t'('0);
		end
	end

	always_comb begin
		push.r0 = '{out_byte: e0, byte_valid: 1'b1, run_last: (cnt == 2'd1),
			frame_end: (cnt == 2'd1) && last_s1};
		push.r1 = '{out_byte: e1, byte_valid: 1'b1, run_last: 1'b1, frame_end: last_s1};
		push.n  = 2'd0;
		if (fire) begin
			if (cnt == 2'd0) begin
				if (last_s1) begin
					// end-only marker
					push.n  = 2'd1;
					push.r0 = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1,
						frame_end: 1'b1};
				end
			end else begin
				push.n = cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= slsf_pkg::slsf_state_t'('0);
		end else if (fire) begin
			st_q <= st_d;
		end
	end

`ifndef SYNTHESIS
	a_held_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.backslash_held && st_q.skip_lf_next))
		else $error("backslash held while an lf skip is pending");
	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> st_q == slsf_pkg::slsf_state_t'('0))
		else $error("state not cleared after frame end");
	a_no_push_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> push.n == 2'd0)
		else $error("results written without queue room");
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |-> push.n != 2'd0)
		else $error("last byte produced no result");
`endif

endmodule

FILE: rtl/slsf_outq.sv
// slsf_outq: result queue, up to two writes and one read per cycle
// depends on slsf_pkg and slsf_out_if
`timescale 1ns / 1ps

module slsf_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  slsf_pkg::slsf_push_t push,
	output logic                room,
	slsf_out_if.source          flat
);

	slsf_pkg::slsf_res_t               mem_q [slsf_pkg::OUTQ_DEPTH];
	logic [slsf_pkg::OUTQ_AW-1:0]      wr_q;
	logic [slsf_pkg::OUTQ_AW-1:0]      rd_q;
	logic [slsf_pkg::OUTQ_CW-1:0]      count_q;
	logic                              pop;
	slsf_pkg::slsf_res_t               head;

	assign room = count_q <= slsf_pkg::OUTQ_CW'(slsf_pkg::OUTQ_DEPTH - slsf_pkg::MAX_PUSH);
	assign pop  = flat.valid && flat.ready;
	assign head = mem_q[rd_q];

	assign flat.valid      = count_q != '0;
	assign flat.out_byte   = head.out_byte;
	assign flat.byte_valid = head.byte_valid;
	assign flat.run_last   = head.run_last;
	assign flat.frame_end  = head.frame_end;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + slsf_pkg::OUTQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + slsf_pkg::OUTQ_AW'(push.n);
			rd_q    <= rd_q + slsf_pkg::OUTQ_AW'(pop);
			count_q <= count_q + slsf_pkg::OUTQ_CW'(push.n) - slsf_pkg::OUTQ_CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slsf_pkg::OUTQ_CW'(slsf_pkg::OUTQ_DEPTH))
		else $error("result queue overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		slsf_pkg::OUTQ_AW'(wr_q - rd_q) == slsf_pkg::OUTQ_AW'(count_q))
		else $error("queue pointers disagree with count");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> count_q == $past(count_q) - slsf_pkg::OUTQ_CW'(1))
		else $error("queue count wrong after read");
`endif

endmodule

FILE: rtl/source_line_splice_filter_unit.sv
// source_line_splice_filter_unit: top level of the source line splice filter
// depends on slsf_pkg, slsf_in_if, slsf_out_if, slsf_core and slsf_outq
//
//   port   modport              fields                                      role
//   raw    slsf_in_if.sink      data_byte, frame_last                       source text bytes
//   flat   slsf_out_if.source   out_byte, byte_valid, run_last, frame_end   flattened text
//
// one byte accepted per cycle unless raw stalls; its results pass the input register and then the result queue to flat
// a byte that yields two results takes two entries of the result queue
// raw stalls when the input register holds a byte and the four-entry result queue has fewer than two free entries
// reset clears the scanner state and the queue at once, no clearing pass
`timescale 1ns / 1ps

module source_line_splice_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	slsf_in_if.sink     raw,
	slsf_out_if.source  flat
);

	slsf_pkg::slsf_push_t push;
	logic                 room;

	slsf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.room   (room),
		.push   (push)
	);

	slsf_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.flat   (flat)
	);

endmodule
